>>> design/assert_macros.svh
// Assertion macros shared by the scene lock morph table RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLMT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slmt: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SLMT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slmt: next-cycle check failed");

`endif

>>> design/slmt_pkg.sv
// Shared types and constants for the scene lock morph table.
// No dependencies; slmt_morph and scene_lock_morph_table_unit import this package.
package slmt_pkg;

  localparam int SCENE_W    = 4;
  localparam int ADDR_W     = 11;
  localparam int ADDRS      = 2048;
  localparam int VAL_W      = 7;
  localparam int ENTRY_W    = 8;
  localparam int CNT_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [7:0] NV_MAX = 8'd127;

  // Rounded division by 127 done as floor((num + 63) * DIV_MULT / 2^DIV_SHIFT).
  localparam logic [6:0]  ROUND_BIAS = 7'd63;
  localparam logic [14:0] DIV_MULT   = 15'd16514;
  localparam int          DIV_SHIFT  = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_SCENE_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCENE_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_A  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_B  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FADER   = 3'd4;

  typedef enum logic [2:0] {
    ACT_SETLOCK    = 3'd0,
    ACT_CLEARLOCK  = 3'd1,
    ACT_CLEARSCENE = 3'd2,
    ACT_SETBASE    = 3'd3,
    ACT_GETBASE    = 3'd4,
    ACT_GETLOCK    = 3'd5,
    ACT_MORPH      = 3'd6,
    ACT_HASLOCKS   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_MORPH_B,
    S_MORPH_Q,
    S_SWEEP
  } state_t;

  typedef struct packed {
    action_t              action;
    logic [SCENE_W-1:0]   scene;
    logic [3:0]           track;
    logic [3:0]           page;
    logic [2:0]           param_slot;
    logic [7:0]           new_value;
    logic [VAL_W-1:0]     base_in;
  } in_t;

  typedef struct packed {
    logic             ok;
    logic             found;
    logic [VAL_W-1:0] result_value;
  } out_t;

endpackage

>>> design/slmt_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Generic storage; no package dependency.
module slmt_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/slmt_morph.sv
// Two-stage morph datapath: interpolation product, then rounded divide by 127.
// Depends on slmt_pkg for widths and the reciprocal constants.
module slmt_morph (
  input  logic                      clk,
  input  logic                      stage_en,
  input  logic [slmt_pkg::VAL_W-1:0] side_a,
  input  logic [slmt_pkg::VAL_W-1:0] side_b,
  input  logic [slmt_pkg::VAL_W-1:0] fader,
  output logic [slmt_pkg::VAL_W-1:0] result
);
  import slmt_pkg::*;

  logic signed [7:0]  diff;
  logic signed [15:0] prod;
  logic [VAL_W-1:0]   a_r;
  logic signed [15:0] prod_r;
  logic [13:0]        a127;
  logic signed [15:0] num_s;
  logic [28:0]        quot_full;

  assign diff = $signed({1'b0, side_b}) - $signed({1'b0, side_a});
  assign prod = diff * $signed({1'b0, fader});

  always_ff @(posedge clk) begin
    if (stage_en) begin
      a_r    <= side_a;
      prod_r <= prod;
    end
  end

  // The interpolated numerator lies in 0..127*127, so after the rounding bias
  // it fits in 14 unsigned bits and the reciprocal product is exact.
  assign a127      = {a_r, 7'd0} - {7'd0, a_r};
  assign num_s     = $signed({2'b00, a127}) + prod_r + $signed({9'd0, ROUND_BIAS});
  assign quot_full = num_s[13:0] * DIV_MULT;
  assign result    = quot_full[DIV_SHIFT +: VAL_W];

endmodule

>>> design/scene_lock_morph_table_unit.sv
// Handshake: an item is taken when start is high and busy is low; each item
// produces exactly one result, shown on out_data for the single cycle that
// out_strobe is high, and the receiver cannot hold it off. After reset the
// block clears both memories in one pass over every lock entry with busy
// high. Set, clear, read, lock-count and base actions do one lock/base memory
// read, then the read-modify-write. Morph reads both scene locks through the
// single read port of the lock memory one after the other, and the divide by
// 127 runs as a registered multiply. Clearing a scene walks its 2048 lock
// entries, one write per cycle.
`include "assert_macros.svh"

module scene_lock_morph_table_unit #(
  parameter int SCENES = 16,
  parameter int TRACKS = 16,
  parameter int PAGES  = 16,
  parameter int SLOTS  = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  slmt_pkg::in_t                    in_data,
  output logic                             busy,
  output logic                             out_strobe,
  output slmt_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [slmt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [slmt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import slmt_pkg::*;

  localparam int SCENE_IW   = $clog2(SCENES);
  localparam int LOCK_AW    = SCENE_IW + ADDR_W;
  localparam int LOCK_DEPTH = SCENES * ADDRS;

  function automatic logic scene_in(input logic [SCENE_W-1:0] s);
    return int'(s) < SCENES;
  endfunction

  function automatic logic addr_in(input in_t it);
    return (int'(it.track) < TRACKS) && (int'(it.page) < PAGES) &&
           (int'(it.param_slot) < SLOTS);
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input in_t it);
    return {it.track, it.page, it.param_slot};
  endfunction

  function automatic logic [LOCK_AW-1:0] lock_addr(input logic [SCENE_W-1:0] s,
                                                   input logic [ADDR_W-1:0] a);
    return {s[SCENE_IW-1:0], a};
  endfunction

  function automatic logic [VAL_W-1:0] side_val(input logic mute, input logic sok,
                                                input logic [ENTRY_W-1:0] e,
                                                input logic [VAL_W-1:0] base);
    return (!mute && sok && e[VAL_W]) ? e[VAL_W-1:0] : base;
  endfunction

  state_t               state_r, state_nxt;
  in_t                  item_r, item_nxt;
  logic [LOCK_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [VAL_W-1:0]     side_a_r, side_a_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  out_t                 out_data_r, out_data_nxt;

  logic [SCENE_W-1:0]   scene_a_r, scene_b_r;
  logic                 mute_a_r, mute_b_r;
  logic [VAL_W-1:0]     fader_r;

  logic [CNT_W-1:0]     cnt_r [SCENES];
  logic [SCENE_IW-1:0]  cnt_idx;
  logic                 cnt_inc, cnt_dec, cnt_clr;

  logic                 lock_we, lock_re;
  logic [LOCK_AW-1:0]   lock_waddr, lock_raddr;
  logic [ENTRY_W-1:0]   lock_wdata, lock_rdata;
  logic                 base_we, base_re;
  logic [ADDR_W-1:0]    base_waddr, base_raddr;
  logic [ENTRY_W-1:0]   base_wdata, base_rdata;

  logic                 morph_en;
  logic [VAL_W-1:0]     morph_q;
  logic [VAL_W-1:0]     side_b;

  logic [ADDR_W-1:0]    in_addr, it_addr;
  logic                 it_sok, sa_ok, sb_ok, lock_valid, value_ok;

  assign in_addr    = addr_of(in_data);
  assign it_addr    = addr_of(item_r);
  assign it_sok     = scene_in(item_r.scene);
  assign sa_ok      = scene_in(scene_a_r);
  assign sb_ok      = scene_in(scene_b_r);
  assign lock_valid = lock_rdata[VAL_W];
  assign value_ok   = item_r.new_value <= NV_MAX;
  assign cnt_idx    = item_r.scene[SCENE_IW-1:0];
  assign side_b     = side_val(mute_b_r, sb_ok, lock_rdata, item_r.base_in);

  slmt_ram #(
    .DEPTH (LOCK_DEPTH),
    .AW    (LOCK_AW),
    .DW    (ENTRY_W)
  ) u_lock_ram (
    .clk   (clk),
    .we    (lock_we),
    .waddr (lock_waddr),
    .wdata (lock_wdata),
    .re    (lock_re),
    .raddr (lock_raddr),
    .rdata (lock_rdata)
  );

  slmt_ram #(
    .DEPTH (ADDRS),
    .AW    (ADDR_W),
    .DW    (ENTRY_W)
  ) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (base_waddr),
    .wdata (base_wdata),
    .re    (base_re),
    .raddr (base_raddr),
    .rdata (base_rdata)
  );

  slmt_morph u_morph (
    .clk      (clk),
    .stage_en (morph_en),
    .side_a   (side_a_r),
    .side_b   (side_b),
    .fader    (fader_r),
    .result   (morph_q)
  );

  // Items are handled one at a time and a write always lands before the next
  // item's read is issued, so no forwarding path is needed.
  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    clr_cnt_nxt    = clr_cnt_r;
    side_a_nxt     = side_a_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    lock_we        = 1'b0;
    lock_waddr     = lock_addr(item_r.scene, it_addr);
    lock_wdata     = '0;
    lock_re        = 1'b0;
    lock_raddr     = lock_addr(in_data.scene, in_addr);
    base_we        = 1'b0;
    base_waddr     = it_addr;
    base_wdata     = '0;
    base_re        = 1'b0;
    base_raddr     = in_addr;
    cnt_inc        = 1'b0;
    cnt_dec        = 1'b0;
    cnt_clr        = 1'b0;
    morph_en       = 1'b0;

    unique case (state_r)
      S_INIT: begin
        lock_we    = 1'b1;
        lock_waddr = clr_cnt_r;
        base_we    = (clr_cnt_r[LOCK_AW-1:ADDR_W] == '0);
        base_waddr = clr_cnt_r[ADDR_W-1:0];
        if (clr_cnt_r == LOCK_AW'(LOCK_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          item_nxt  = in_data;
          state_nxt = S_EXEC;
          base_re   = 1'b1;
          if (in_data.action == ACT_MORPH) begin
            lock_re    = sa_ok;
            lock_raddr = lock_addr(scene_a_r, in_addr);
          end else begin
            lock_re = scene_in(in_data.scene);
          end
        end
      end

      S_EXEC: begin
        out_strobe_nxt = 1'b1;
        out_data_nxt   = '0;
        state_nxt      = S_IDLE;
        unique case (item_r.action)
          ACT_SETLOCK: begin
            if (it_sok && addr_in(item_r) && value_ok) begin
              lock_we         = 1'b1;
              lock_wdata      = {1'b1, item_r.new_value[VAL_W-1:0]};
              cnt_inc         = !lock_valid;
              out_data_nxt.ok = 1'b1;
            end
          end
          ACT_CLEARLOCK: begin
            if (it_sok && lock_valid) begin
              lock_we         = 1'b1;
              cnt_dec         = 1'b1;
              out_data_nxt.ok = 1'b1;
            end
          end
          ACT_CLEARSCENE: begin
            if (it_sok) begin
              cnt_clr        = 1'b1;
              clr_cnt_nxt    = '0;
              out_strobe_nxt = 1'b0;
              state_nxt      = S_SWEEP;
            end
          end
          ACT_SETBASE: begin
            if (addr_in(item_r) && value_ok) begin
              base_we         = 1'b1;
              base_wdata      = {1'b1, item_r.new_value[VAL_W-1:0]};
              out_data_nxt.ok = 1'b1;
            end
          end
          ACT_GETBASE: begin
            out_data_nxt.ok = 1'b1;
            if (base_rdata[VAL_W]) begin
              out_data_nxt.found        = 1'b1;
              out_data_nxt.result_value = base_rdata[VAL_W-1:0];
            end
          end
          ACT_GETLOCK: begin
            if (it_sok) begin
              out_data_nxt.ok = 1'b1;
              if (lock_valid) begin
                out_data_nxt.found        = 1'b1;
                out_data_nxt.result_value = lock_rdata[VAL_W-1:0];
              end
            end
          end
          ACT_MORPH: begin
            side_a_nxt     = side_val(mute_a_r, sa_ok, lock_rdata, item_r.base_in);
            lock_re        = sb_ok;
            lock_raddr     = lock_addr(scene_b_r, it_addr);
            out_strobe_nxt = 1'b0;
            state_nxt      = S_MORPH_B;
          end
          ACT_HASLOCKS: begin
            out_data_nxt.ok    = 1'b1;
            out_data_nxt.found = it_sok && (cnt_r[cnt_idx] != '0);
          end
          default: begin
            out_data_nxt = '0;
          end
        endcase
      end

      S_MORPH_B: begin
        morph_en  = 1'b1;
        state_nxt = S_MORPH_Q;
      end

      S_MORPH_Q: begin
        out_strobe_nxt            = 1'b1;
        out_data_nxt              = '0;
        out_data_nxt.ok           = 1'b1;
        out_data_nxt.result_value = morph_q;
        state_nxt                 = S_IDLE;
      end

      S_SWEEP: begin
        lock_we    = 1'b1;
        lock_waddr = lock_addr(item_r.scene, clr_cnt_r[ADDR_W-1:0]);
        if (clr_cnt_r[ADDR_W-1:0] == ADDR_W'(ADDRS - 1)) begin
          out_strobe_nxt  = 1'b1;
          out_data_nxt    = '0;
          out_data_nxt.ok = 1'b1;
          state_nxt       = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      clr_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    side_a_r   <= side_a_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SCENES; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cnt_clr) begin
      cnt_r[cnt_idx] <= '0;
    end else if (cnt_inc) begin
      cnt_r[cnt_idx] <= cnt_r[cnt_idx] + 1'b1;
    end else if (cnt_dec) begin
      cnt_r[cnt_idx] <= cnt_r[cnt_idx] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scene_a_r <= '0;
      scene_b_r <= '0;
      mute_a_r  <= 1'b0;
      mute_b_r  <= 1'b0;
      fader_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCENE_A: scene_a_r <= cfg_wdata[SCENE_W-1:0];
        CFG_SCENE_B: scene_b_r <= cfg_wdata[SCENE_W-1:0];
        CFG_MUTE_A:  mute_a_r  <= cfg_wdata[0];
        CFG_MUTE_B:  mute_b_r  <= cfg_wdata[0];
        CFG_FADER:   fader_r   <= cfg_wdata[VAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `SLMT_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `SLMT_ASSERT_SAME(a_result_follows_work, out_strobe_r, $past(state_r) != S_IDLE)
  `SLMT_ASSERT_SAME(a_no_lock_write_idle, state_r == S_IDLE, !lock_we && !base_we)
  `SLMT_ASSERT_SAME(a_found_implies_ok, out_strobe_r && out_data_r.found, out_data_r.ok)

endmodule
